[rtl/sbda_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the BCD shift-add-3 step for the converter.
// No dependencies.
package sbda_pkg;
  localparam int MAX_DIGITS = 20;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int IDX_W      = 5;

  typedef logic [5:0]       ascii_t;
  typedef logic [3:0]       digit_t;
  typedef logic [BCD_W-1:0] bcd_t;

  localparam ascii_t CHR_ZERO  = 6'd48;
  localparam ascii_t CHR_MINUS = 6'd45;
  localparam digit_t DIG_FIVE  = 4'd5;
  localparam digit_t DIG_THREE = 4'd3;

  // Result of the conversion pipeline as handed to the character stage.
  typedef struct packed {
    logic neg;
    bcd_t bcd;
  } conv_t;

  // One double-dabble step: correct every digit, then shift in one bit.
  function automatic bcd_t dabble_step(bcd_t bcd, logic b);
    bcd_t adj;
    adj = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (adj[i*4 +: 4] >= DIG_FIVE) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + DIG_THREE;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction
endpackage

[rtl/signed_binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// Signed binary to decimal ASCII converter, top level.
// An input passes the front, dabble and character stages before its first character.
// The conversion pipeline takes a value every cycle unless stalled; the character
// stage sends one character per cycle while out_ready is high, sign then digits.
// Reset (rst_n low, synchronous) clears all valid bits; no character is pending.
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_ascii_char,
  output logic        out_last
);
  import sbda_pkg::*;

  localparam int STEP = 8;
  localparam int NSTG = (VALUE_BITS + STEP - 1) / STEP;

  logic [VALUE_BITS-1:0] mag_s [NSTG+1];
  conv_t                 res_s [NSTG+1];
  logic                  v_s   [NSTG+1];
  logic                  r_s   [NSTG+1];

  sbda_front #(.W(VALUE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value),
    .out_valid(v_s[0]), .out_ready(r_s[0]), .out_mag(mag_s[0]), .out_res(res_s[0])
  );

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    sbda_dabble #(.W(VALUE_BITS), .BASE(g * STEP), .NB(STEP)) u_dabble (
      .clk(clk), .rst_n(rst_n),
      .in_valid(v_s[g]), .in_ready(r_s[g]), .in_mag(mag_s[g]), .in_res(res_s[g]),
      .out_valid(v_s[g+1]), .out_ready(r_s[g+1]),
      .out_mag(mag_s[g+1]), .out_res(res_s[g+1])
    );
  end

  sbda_serial u_serial (
    .clk(clk), .rst_n(rst_n),
    .in_valid(v_s[NSTG]), .in_ready(r_s[NSTG]), .in_res(res_s[NSTG]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ascii_char(out_ascii_char), .out_last(out_last)
  );
endmodule

[rtl/sbda_front.sv]
`timescale 1ns / 1ps
// Input stage: sign detection and magnitude of the low W bits of the value.
// Depends on sbda_pkg.
module sbda_front #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [W-1:0]         out_mag,
  output sbda_pkg::conv_t      out_res
);
  import sbda_pkg::*;

  logic         valid_r;
  logic [W-1:0] mag_r;
  logic         neg_r;
  logic [W-1:0] raw;

  assign raw      = in_value[W-1:0];
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      neg_r <= raw[W-1];
      // Unsigned negation also gives the right magnitude for the most negative value.
      mag_r <= raw[W-1] ? (~raw + {{(W-1){1'b0}}, 1'b1}) : raw;
    end
  end

  assign out_valid   = valid_r;
  assign out_mag     = mag_r;
  assign out_res.neg = neg_r;
  assign out_res.bcd = '0;
endmodule

[rtl/sbda_dabble.sv]
`timescale 1ns / 1ps
// One pipeline stage of the binary to BCD conversion, up to NB bits per stage.
// Depends on sbda_pkg.
module sbda_dabble #(
  parameter int W    = 64,
  parameter int BASE = 0,
  parameter int NB   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [W-1:0]    in_mag,
  input  sbda_pkg::conv_t in_res,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [W-1:0]    out_mag,
  output sbda_pkg::conv_t out_res
);
  import sbda_pkg::*;

  logic         valid_r;
  logic [W-1:0] mag_r;
  conv_t        res_r;
  logic [W-1:0] mag_nxt;
  conv_t        res_nxt;

  assign in_ready = !valid_r || out_ready;

  // Magnitude bits leave at the top, most significant first.
  always_comb begin
    mag_nxt = in_mag;
    res_nxt = in_res;
    for (int j = 0; j < NB; j++) begin
      if (BASE + j < W) begin
        res_nxt.bcd = dabble_step(res_nxt.bcd, mag_nxt[W-1]);
        mag_nxt     = {mag_nxt[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mag_r <= mag_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_mag   = mag_r;
  assign out_res   = res_r;
endmodule

[rtl/sbda_serial.sv]
`timescale 1ns / 1ps
// Character stage: sends the minus sign and the significant BCD digits.
// Depends on sbda_pkg.
module sbda_serial (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sbda_pkg::conv_t in_res,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      out_ascii_char,
  output logic            out_last
);
  import sbda_pkg::*;

  logic             busy_r;
  logic             neg_r;
  logic [IDX_W-1:0] idx_r;
  bcd_t             bcd_r;
  logic [IDX_W-1:0] top_idx;
  digit_t           cur_digit;
  logic             xfer;

  // Position of the most significant nonzero digit; zero gives position 0.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (in_res.bcd[i*4 +: 4] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign cur_digit      = bcd_r[idx_r*4 +: 4];
  assign out_valid      = busy_r;
  assign out_last       = !neg_r && (idx_r == '0);
  assign out_ascii_char = neg_r ? CHR_MINUS : (CHR_ZERO + {2'b00, cur_digit});
  assign xfer           = busy_r && out_ready;
  assign in_ready       = !busy_r || (xfer && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      neg_r  <= 1'b0;
      idx_r  <= '0;
    end else if (in_valid && in_ready) begin
      busy_r <= 1'b1;
      neg_r  <= in_res.neg;
      idx_r  <= top_idx;
    end else if (xfer) begin
      if (neg_r) begin
        neg_r <= 1'b0;
      end else if (idx_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bcd_r <= in_res.bcd;
    end
  end

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && neg_r) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_last && out_ready) |=> busy_r)
    else $error("character run ended before last character");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_char == CHR_MINUS ||
                   (out_ascii_char >= CHR_ZERO && out_ascii_char <= CHR_ZERO + 6'd9)))
    else $error("character out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < IDX_W'(MAX_DIGITS)))
    else $error("digit index out of range");
endmodule
